[src/scenery_command_stream_parser_core_macros.svh]
// Assertion macros for the scenery command stream parser.
`ifndef SCENERY_COMMAND_STREAM_PARSER_CORE_MACROS_SVH
`define SCENERY_COMMAND_STREAM_PARSER_CORE_MACROS_SVH
// Implication checked on every clock, held off during reset.
`define SCP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SCP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/scp_pkg.sv]
// Package: constants, types and decode functions of the scenery command parser.
package scp_pkg;

  localparam int OpcodeSlots = 35;
  localparam int CounterBits = 40;
  localparam int OfsBits = 40;
  localparam int NumStats = 8;
  localparam int NumEntries = 1 + NumStats + OpcodeSlots;
  localparam int IdBits = 6;
  localparam int AddrBits = $clog2(NumEntries);

  localparam logic [CounterBits-1:0] CntMax = {CounterBits{1'b1}};
  localparam logic [OfsBits-1:0] OfsMax = {OfsBits{1'b1}};

  localparam logic [2:0] PH_OPC    = 3'd0;
  localparam logic [2:0] PH_HEAD   = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_LOD    = 3'd3;
  localparam logic [2:0] PH_RCOUNT = 3'd4;
  localparam logic [2:0] PH_RLIST  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_RESV    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // one memory update request from the parser
  typedef struct packed {
    logic                   hist_en;
    logic [AddrBits-1:0]    hist_addr;
    logic                   stat_en;
    logic [2:0]             stat_idx;
    logic                   tri_en;
    logic [31:0]            tri_amount;
  } upd_t;

  function automatic logic [2:0] head_len(input logic [5:0] op);
    unique case (op)
      6'd12, 6'd14: head_len = 3'd3;
      6'd15: head_len = 3'd5;
      6'd25, 6'd28, 6'd31, 6'd34: head_len = 3'd4;
      6'd33: head_len = 3'd2;
      default: head_len = 3'd1;
    endcase
  endfunction

  function automatic logic [2:0] fixed_len(input logic [7:0] op);
    unique case (op)
      8'd1, 8'd4, 8'd7: fixed_len = 3'd2;
      8'd2, 8'd5, 8'd8, 8'd10: fixed_len = 3'd4;
      8'd3, 8'd6, 8'd17: fixed_len = 3'd1;
      8'd13: fixed_len = 3'd6;
      default: fixed_len = 3'd0;
    endcase
  endfunction

  // statistics counter bumped at command completion; bit 3 set means none
  function automatic logic [3:0] stat_of(input logic [5:0] op);
    if (op == 6'd1) stat_of = 4'd0;
    else if (op >= 6'd3 && op <= 6'd5) stat_of = 4'd1;
    else if (op == 6'd7 || op == 6'd8) stat_of = 4'd2;
    else if (op >= 6'd9 && op <= 6'd11) stat_of = 4'd3;
    else if (op >= 6'd12 && op <= 6'd15) stat_of = 4'd4;
    else if (op >= 6'd16 && op <= 6'd18) stat_of = 4'd5;
    else if (op >= 6'd23 && op <= 6'd31) stat_of = 4'd6;
    else stat_of = 4'd8;
  endfunction

endpackage

[src/scenery_command_stream_parser_core.sv]
// Per byte beat: a beat can start up to two counter updates (histogram, statistic
// or vertex sum), and input then stalls until they are all written back.
// Report: after the stream_end beat the updates drain, then 44 beats follow, each a
// memory read and then the output register, with one read in flight at most.
// A sweep then clears the histogram; input resumes once the last beat left.
// rst is synchronous active high; per-entry valid bits make all counters read zero.
module scenery_command_stream_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], byte_valid[8], zero[15:9]
  input  logic        s_tlast,   // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // counter_id[5:0], counter_value[45:6], zero[47:46]
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast    // run_last
);

  localparam logic [1:0] S_RUN = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_REP = 2'd2;
  localparam logic [1:0] S_CLR = 2'd3;

  logic [1:0] state;
  logic take, acc, pend, busy, rd_en, clr_en, restart;
  logic [1:0] err, st_rep;
  logic [scp_pkg::OfsBits-1:0] boff, eoff;
  logic [scp_pkg::AddrBits-1:0] idx, clr_addr;
  logic [scp_pkg::CounterBits-1:0] rd_data;
  logic [scp_pkg::OfsBits-1:0] off_hold;
  logic rd_v, ordy;
  logic [scp_pkg::AddrBits-1:0] rd_i;
  scp_pkg::upd_t upd;

  assign s_tready = (state == S_RUN) && !pend;
  assign acc = s_tvalid && s_tready;
  assign take = acc && s_tdata[8] && (err == scp_pkg::ST_OK);
  assign ordy = !m_tvalid || m_tready;
  // one read in flight at most, so the output register is free when it lands
  assign rd_en = (state == S_REP) && ordy && !rd_v;
  assign clr_en = (state == S_CLR);
  assign clr_addr = idx;
  assign restart = (state == S_CLR) && (idx == scp_pkg::AddrBits'(scp_pkg::NumEntries - 1));

  scp_parser u_parser (
    .clk, .rst, .take, .restart, .data_byte(s_tdata[7:0]), .upd, .busy, .err,
    .byte_offset(boff), .error_offset(eoff)
  );

  scp_counters u_cnt (
    .clk, .rst, .upd, .clr_en(clr_en && idx >= scp_pkg::AddrBits'(9)), .clr_addr,
    .rd_en, .rd_addr(idx), .rd_data, .pend
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      idx <= '0;
      m_tvalid <= 1'b0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= rd_en;
      if (rd_v) begin
        m_tvalid <= 1'b1;
        m_tdata <= {2'b00, (rd_i == '0) ? off_hold : rd_data, 6'(rd_i)};
        m_tuser <= st_rep;
        m_tlast <= (rd_i == scp_pkg::AddrBits'(scp_pkg::NumEntries - 1));
      end else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_RUN: if (acc && s_tlast) state <= S_DRAIN;
        S_DRAIN: if (!pend) begin
          st_rep <= (err == scp_pkg::ST_OK && busy) ? scp_pkg::ST_TRUNC : err;
          off_hold <= (err == scp_pkg::ST_OK && !busy) ? boff : eoff;
          idx <= '0;
          state <= S_REP;
        end
        S_REP: if (rd_en) begin
          if (idx == scp_pkg::AddrBits'(scp_pkg::NumEntries - 1)) begin
            idx <= '0;
            state <= S_CLR;
          end else idx <= idx + 1'b1;
        end
        S_CLR: if (restart) begin
          if (!(m_tvalid || rd_v)) state <= S_RUN;
          else idx <= idx;
          if (!(m_tvalid || rd_v)) idx <= '0;
        end else idx <= idx + 1'b1;
        default: state <= S_RUN;
      endcase
    end
    rd_i <= idx;
  end

endmodule

[src/scp_parser.sv]
// Byte-level command decoder: phases, skip counts, offsets and error latch.
module scp_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,      // valid byte accepted
  input  logic                          restart,   // report taken, start new payload
  input  logic [7:0]                    data_byte,
  output scp_pkg::upd_t                 upd,
  output logic                          busy,      // mid command
  output logic [1:0]                    err,
  output logic [scp_pkg::OfsBits-1:0]   byte_offset,
  output logic [scp_pkg::OfsBits-1:0]   error_offset
);

  logic [2:0]  phase, phase_next;
  logic [5:0]  opcode, opcode_next;
  logic [32:0] skip, skip_next;
  logic [7:0]  rings, rings_next;
  logic [31:0] fa, fa_next;
  logic [1:0]  err_next;
  logic [scp_pkg::OfsBits-1:0] eoff_next, here, nxt;

  assign busy = (phase != scp_pkg::PH_OPC);

  always_comb begin
    logic fin;
    logic [3:0] st;
    logic [2:0] pos, fl;
    logic [7:0] third;
    logic [32:0] lst;
    logic [15:0] lo, hi;
    logic do_list;
    phase_next = phase;
    opcode_next = opcode;
    skip_next = skip;
    rings_next = rings;
    fa_next = fa;
    err_next = err;
    eoff_next = error_offset;
    upd = '0;
    fin = 1'b0;
    st = '0;
    do_list = 1'b0;
    lst = '0;
    here = byte_offset;
    nxt = (byte_offset == scp_pkg::OfsMax) ? byte_offset : byte_offset + 1'b1;
    pos = '0;
    fl = '0;
    third = fa[23:16];
    lo = '0;
    hi = '0;
    if (take) begin
      unique case (phase)
        scp_pkg::PH_OPC: begin
          opcode_next = data_byte[5:0];
          fa_next = '0;
          eoff_next = nxt;
          if (data_byte < 8'(scp_pkg::OpcodeSlots)) begin
            upd.hist_en = 1'b1;
            upd.hist_addr = scp_pkg::AddrBits'(data_byte + 8'd9);
          end
          fl = scp_pkg::fixed_len(data_byte);
          if (data_byte == 8'd0) begin
            err_next = scp_pkg::ST_RESV;
            eoff_next = here;
          end else if (fl != 3'd0) begin
            skip_next = 33'(fl);
            phase_next = scp_pkg::PH_SKIP;
          end else if (data_byte == 8'd16) begin
            fin = 1'b1;
          end else if (data_byte == 8'd18) begin
            skip_next = 33'd8;
            phase_next = scp_pkg::PH_LOD;
          end else if (data_byte == 8'd9 || data_byte == 8'd11 || data_byte == 8'd12 ||
                       data_byte == 8'd14 || data_byte == 8'd15 ||
                       (data_byte >= 8'd23 && data_byte <= 8'd34)) begin
            skip_next = 33'(scp_pkg::head_len(data_byte[5:0]));
            phase_next = scp_pkg::PH_HEAD;
          end else begin
            err_next = scp_pkg::ST_UNKNOWN;
            eoff_next = here;
          end
        end
        scp_pkg::PH_HEAD: begin
          pos = scp_pkg::head_len(opcode) - skip[2:0];
          fa_next = fa | (32'(data_byte) << {pos[1:0], 3'b000});
          skip_next = skip - 1'b1;
          third = fa_next[23:16];
          if (skip == 33'd1) begin
            unique case (opcode)
              6'd12, 6'd15: begin
                do_list = 1'b1;
                lst = 33'({third, 1'b0});
              end
              6'd14: begin
                rings_next = third;
                if (third == 8'd0) fin = 1'b1;
                else begin
                  eoff_next = nxt;
                  phase_next = scp_pkg::PH_RCOUNT;
                end
              end
              6'd25, 6'd28, 6'd31: begin
                lo = fa_next[15:0];
                hi = fa_next[31:16];
                fa_next = (hi > lo) ? 32'(hi - lo) : 32'd0;
                fin = 1'b1;
              end
              6'd33: begin
                do_list = 1'b1;
                lst = 33'(fa_next[15:0]);
              end
              6'd34: begin
                do_list = 1'b1;
                lst = 33'(fa_next);
              end
              6'd32: begin
                do_list = 1'b1;
                lst = 33'(fa_next[7:0]);
              end
              6'd11, 6'd24, 6'd27, 6'd30: begin
                fa_next = 32'(fa_next[7:0]);
                do_list = 1'b1;
                lst = 33'({fa_next[7:0], 2'b00});
              end
              default: begin
                fa_next = 32'(fa_next[7:0]);
                do_list = 1'b1;
                lst = 33'({fa_next[7:0], 1'b0});
              end
            endcase
            if (do_list) begin
              eoff_next = nxt;
              if (lst == '0) fin = 1'b1;
              else begin
                skip_next = lst;
                phase_next = scp_pkg::PH_SKIP;
              end
            end
          end
        end
        scp_pkg::PH_SKIP: begin
          skip_next = skip - 1'b1;
          if (skip == 33'd1) fin = 1'b1;
        end
        scp_pkg::PH_LOD: begin
          skip_next = skip - 1'b1;
          if (skip == 33'd1) begin
            eoff_next = nxt;
            skip_next = 33'd1;
            phase_next = scp_pkg::PH_SKIP;
          end
        end
        scp_pkg::PH_RCOUNT: begin
          rings_next = rings - 1'b1;
          eoff_next = nxt;
          if (data_byte == 8'd0) begin
            if (rings_next == 8'd0) fin = 1'b1;
          end else begin
            skip_next = 33'({data_byte, 1'b0});
            phase_next = scp_pkg::PH_RLIST;
          end
        end
        scp_pkg::PH_RLIST: begin
          skip_next = skip - 1'b1;
          if (skip == 33'd1) begin
            if (rings == 8'd0) fin = 1'b1;
            else begin
              eoff_next = nxt;
              phase_next = scp_pkg::PH_RCOUNT;
            end
          end
        end
        default: phase_next = scp_pkg::PH_OPC;
      endcase
      if (fin) begin
        st = scp_pkg::stat_of(opcode_next);
        if (!st[3]) begin
          upd.stat_en = 1'b1;
          upd.stat_idx = st[2:0];
        end
        if (st == 4'd6) begin
          upd.tri_en = 1'b1;
          upd.tri_amount = fa_next;
        end
        phase_next = scp_pkg::PH_OPC;
        skip_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase <= scp_pkg::PH_OPC;
      opcode <= '0;
      skip <= '0;
      rings <= '0;
      fa <= '0;
      byte_offset <= '0;
      err <= scp_pkg::ST_OK;
      error_offset <= '0;
    end else begin
      phase <= phase_next;
      opcode <= opcode_next;
      skip <= skip_next;
      rings <= rings_next;
      fa <= fa_next;
      err <= err_next;
      error_offset <= eoff_next;
      if (take) byte_offset <= nxt;
    end
  end

endmodule

[src/scp_counters.sv]
// Counter memory: statistics and histogram, read-modify-write and report readout.
module scp_counters (
  input  logic                              clk,
  input  logic                              rst,
  input  scp_pkg::upd_t                     upd,
  input  logic                              clr_en,    // clear sweep write
  input  logic [scp_pkg::AddrBits-1:0]      clr_addr,
  input  logic                              rd_en,     // report read
  input  logic [scp_pkg::AddrBits-1:0]      rd_addr,
  output logic [scp_pkg::CounterBits-1:0]   rd_data,
  output logic                              pend       // write back still due
);

  localparam int W = scp_pkg::CounterBits;

  logic [W-1:0] mem [scp_pkg::NumEntries];
  logic [scp_pkg::NumEntries-1:0] vld;   // entry not valid reads zero

  // stage 1: memory read; stage 2: add and write
  logic                          s_en;
  logic [scp_pkg::AddrBits-1:0]  s_addr;
  logic [32:0]                   s_amt;
  logic                          t_en;
  logic [scp_pkg::AddrBits-1:0]  t_addr;
  logic [32:0]                   t_amt;
  logic [W-1:0]                  q, last_wr, base, sum_w;
  logic [scp_pkg::AddrBits-1:0]  last_addr;
  logic                          last_en;
  logic [W:0]                    sum;

  // Pending update slots from one beat, served one per cycle in order:
  // histogram, statistic, vertex sum.
  logic                          h_en, st_en, tr_en;
  logic [scp_pkg::AddrBits-1:0]  h_addr, st_addr;
  logic [31:0]                   tr_amt;

  assign pend = h_en | st_en | tr_en | s_en | t_en;

  always_comb begin
    s_en = 1'b0;
    s_addr = '0;
    s_amt = '0;
    priority if (h_en) begin
      s_en = 1'b1;
      s_addr = h_addr;
      s_amt = 33'd1;
    end else if (st_en) begin
      s_en = 1'b1;
      s_addr = st_addr;
      s_amt = 33'd1;
    end else if (tr_en) begin
      s_en = 1'b1;
      s_addr = scp_pkg::AddrBits'(8);
      s_amt = 33'(tr_amt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_en <= 1'b0;
      st_en <= 1'b0;
      tr_en <= 1'b0;
    end else begin
      if (upd.hist_en | upd.stat_en | upd.tri_en) begin
        h_en <= upd.hist_en;
        st_en <= upd.stat_en;
        tr_en <= upd.tri_en;
      end else if (h_en) h_en <= 1'b0;
      else if (st_en) st_en <= 1'b0;
      else tr_en <= 1'b0;
    end
    if (upd.hist_en | upd.stat_en | upd.tri_en) begin
      h_addr <= upd.hist_addr;
      st_addr <= scp_pkg::AddrBits'(upd.stat_idx + 4'd1);
      tr_amt <= upd.tri_amount;
    end
  end

  always_ff @(posedge clk) begin
    q <= mem[rd_en ? rd_addr : s_addr];
    if (t_en) mem[t_addr] <= sum_w;
    else if (clr_en) mem[clr_addr] <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      t_en <= 1'b0;
      last_en <= 1'b0;
    end else begin
      t_en <= s_en & ~rd_en;
      last_en <= t_en;
      if (t_en) vld[t_addr] <= 1'b1;
      else if (clr_en) vld[clr_addr] <= 1'b0;
    end
    t_addr <= s_addr;
    t_amt <= s_amt;
    last_addr <= t_addr;
    last_wr <= sum_w;
  end

  always_comb begin
    base = vld[t_addr] ? q : '0;
    if (last_en && last_addr == t_addr) base = last_wr;
    sum = {1'b0, base} + (W+1)'(t_amt);
    sum_w = sum[W] ? scp_pkg::CntMax : sum[W-1:0];
  end

  logic [scp_pkg::AddrBits-1:0] r_addr;
  logic r_en;
  always_ff @(posedge clk) begin
    r_addr <= rd_addr;
    r_en <= rd_en;
  end
  assign rd_data = (r_en && vld[r_addr]) ? q : '0;

endmodule

[src/scp_checker.sv]
// Port-level checker for the scenery command stream parser, bound to the top.
`include "scenery_command_stream_parser_core_macros.svh"
module scp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast
);
  `SCP_ASSERT_IMP(a_last_id, m_tvalid && m_tlast, m_tdata[5:0] == 6'd43)
  `SCP_ASSERT_IMP(a_id_range, m_tvalid, m_tdata[5:0] <= 6'd43)
  `SCP_ASSERT_IMP(a_no_in_mid, m_tvalid && !m_tlast, !s_tready)
  `SCP_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind scenery_command_stream_parser_core scp_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
